### rtl/core/ptds_pkg.sv
// ----------------------------------------------------------------------------
// ptds_pkg
// Shared types and constants for the periodic task deadline scheduler.
// ----------------------------------------------------------------------------
package ptds_pkg;

    localparam int TASKS_DEF = 16;
    localparam int ID_W      = 4;
    localparam int TIME_W    = 32;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_POLL = 2'd2,
        MODE_DONE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNLINK,
        ST_WALK,
        ST_INSERT,
        ST_OUT
    } t_state;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             unlink;     // drop entry holding key_id, close gap
        logic             ins;        // insert key at ins_pos, open gap
        logic [8:0]       ins_pos;
        logic [ID_W-1:0]  key_id;
        logic [TIME_W-1:0] key_base;
        logic [TIME_W-1:0] key_period;
    } t_cmd;

endpackage

### rtl/core/ptds_if.sv
// ----------------------------------------------------------------------------
// ptds_in_if / ptds_out_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface ptds_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  task_id;
    logic [31:0] task_period;
    logic [31:0] now_time;
    logic        failed;
    modport source (output valid, mode, task_id, task_period, now_time, failed,
                    input ready);
    modport sink   (input valid, mode, task_id, task_period, now_time, failed,
                    output ready);
endinterface

interface ptds_out_if;
    logic       valid;
    logic       ready;
    logic       start_valid;
    logic [3:0] start_id;
    logic       list_empty;
    logic       status;
    modport source (output valid, start_valid, start_id, list_empty, status,
                    input ready);
    modport sink   (input valid, start_valid, start_id, list_empty, status,
                    output ready);
endinterface

### rtl/core/ptds_cell.sv
// ----------------------------------------------------------------------------
// ptds_cell
// One list position: holds slot id, base and period. Shifts with neighbors
// on unlink (take right) or insert (take left).
// ----------------------------------------------------------------------------
module ptds_cell #(
    parameter int POS = 0
) (
    input  logic                     i_clk,
    input  ptds_pkg::t_cmd           i_cmd,
    input  logic                     i_gap_left,   // unlink gap opened left of me
    input  logic [ptds_pkg::ID_W-1:0]   i_r_id,
    input  logic [ptds_pkg::TIME_W-1:0] i_r_base,
    input  logic [ptds_pkg::TIME_W-1:0] i_r_period,
    input  logic [ptds_pkg::ID_W-1:0]   i_l_id,
    input  logic [ptds_pkg::TIME_W-1:0] i_l_base,
    input  logic [ptds_pkg::TIME_W-1:0] i_l_period,
    output logic                     o_gap,        // gap at or left of me
    output logic [ptds_pkg::ID_W-1:0]   o_id,
    output logic [ptds_pkg::TIME_W-1:0] o_base,
    output logic [ptds_pkg::TIME_W-1:0] o_period
);
    logic [ptds_pkg::ID_W-1:0]   r_id;
    logic [ptds_pkg::TIME_W-1:0] r_base, r_period;
    logic [8:0] w_pos;

    assign w_pos    = 9'(POS);
    assign o_gap    = i_gap_left || (r_id == i_cmd.key_id);
    assign o_id     = r_id;
    assign o_base   = r_base;
    assign o_period = r_period;

    always_ff @(posedge i_clk) begin
        if (i_cmd.unlink && o_gap) begin
            r_id     <= i_r_id;
            r_base   <= i_r_base;
            r_period <= i_r_period;
        end else if (i_cmd.ins && w_pos == i_cmd.ins_pos) begin
            r_id     <= i_cmd.key_id;
            r_base   <= i_cmd.key_base;
            r_period <= i_cmd.key_period;
        end else if (i_cmd.ins && w_pos > i_cmd.ins_pos) begin
            r_id     <= i_l_id;
            r_base   <= i_l_base;
            r_period <= i_l_period;
        end
    end
endmodule

### rtl/core/periodic_task_deadline_scheduler_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_deadline_scheduler_unit
// Earliest-deadline ordered list of periodic tasks held in a chain of cells.
// ----------------------------------------------------------------------------
// One word in, one word out. Add, delete, poll and a rejected or failed
// completion go from the accept through the unlink step to the output
// state; a successful completion goes on from the unlink step through the
// walk and insert steps. The deadline compare walks past at most TASKS - 1
// list entries (the task itself was unlinked), one compare per cycle
// through a single head-to-tail position counter. The next word is taken
// only once the result has moved to the output register. The list lives
// in a row of TASKS cells, each holding slot id, base and period; unlink
// closes the gap by shifting right-hand cells left, insert opens one by
// shifting right. Only positions below the list count are meaningful.
// A new word is taken while the previous result waits in the output
// register; the block then holds its own result, and the input, until
// that word has left.
// ----------------------------------------------------------------------------
module periodic_task_deadline_scheduler_unit #(
    parameter int TASKS = ptds_pkg::TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptds_in_if.sink     i_req,
    ptds_out_if.source  o_rsp
);
    localparam int CW = $clog2(TASKS + 1);
    localparam int PW = (TASKS > 1) ? $clog2(TASKS) : 1;

    ptds_pkg::t_state r_state, n_state;

    // latched request
    logic [1:0]  r_mode;
    logic [3:0]  r_tid;
    logic [31:0] r_per, r_now;
    logic        r_fail;

    logic [CW-1:0] r_cnt;
    logic [TASKS-1:0] r_listed;
    logic        r_run;
    logic [3:0]  r_run_id;
    logic [31:0] r_run_base, r_run_per;   // times of the running task
    logic [CW-1:0] r_pos;
    logic [31:0] r_kbase, r_kper;

    // working result
    logic        r_sv, r_status;
    logic [3:0]  r_sid;

    // output register
    logic        r_ovalid, r_o_sv, r_o_status, r_o_empty;
    logic [3:0]  r_o_sid;

    ptds_pkg::t_cmd w_cmd;

    // cell chain wires
    logic [TASKS:0] w_gap;
    logic [3:0]  w_id  [TASKS+1];
    logic [31:0] w_bs  [TASKS+1];
    logic [31:0] w_pr  [TASKS+1];

    assign w_gap[0] = 1'b0;
    assign w_id[TASKS] = '0;
    assign w_bs[TASKS] = '0;
    assign w_pr[TASKS] = '0;

    for (genvar g = 0; g < TASKS; g++) begin : g_cell
        logic [3:0]  w_lid;
        logic [31:0] w_lbs, w_lpr;
        if (g == 0) begin : g_first
            assign w_lid = '0;
            assign w_lbs = '0;
            assign w_lpr = '0;
        end else begin : g_rest
            assign w_lid = w_id[g-1];
            assign w_lbs = w_bs[g-1];
            assign w_lpr = w_pr[g-1];
        end
        ptds_cell #(.POS(g)) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_gap_left (w_gap[g]),
            .i_r_id     (w_id[g+1]),
            .i_r_base   (w_bs[g+1]),
            .i_r_period (w_pr[g+1]),
            .i_l_id     (w_lid),
            .i_l_base   (w_lbs),
            .i_l_period (w_lpr),
            .o_gap      (w_gap[g+1]),
            .o_id       (w_id[g]),
            .o_base     (w_bs[g]),
            .o_period   (w_pr[g])
        );
    end

    // request decode
    logic w_id_ok, w_is_listed, w_acc, w_out_load;
    logic [PW-1:0] w_tidx, w_ridx, w_pidx;
    assign w_tidx   = PW'(r_tid);
    assign w_ridx   = PW'(r_run_id);
    assign w_id_ok  = ({28'd0, r_tid} < 32'(TASKS));
    assign w_is_listed = w_id_ok && r_listed[w_tidx];
    assign w_pidx   = r_pos[PW-1:0];

    // head due check and walk compare
    logic [31:0] w_elapsed, w_mine, w_theirs;
    logic        w_due, w_less, w_walk_end;
    assign w_elapsed = r_now - w_bs[0];
    assign w_due     = (w_elapsed >= w_pr[0]);
    assign w_mine    = r_kbase + r_kper - r_now;
    assign w_theirs  = w_bs[w_pidx] + w_pr[w_pidx] - r_now;
    assign w_less    = $signed(w_mine) < $signed(w_theirs);
    assign w_walk_end = (r_pos >= r_cnt) || w_less;

    assign w_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ptds_pkg::ST_IDLE);

    // result moves to the output register once the previous word has left
    assign w_out_load = (r_state == ptds_pkg::ST_OUT) && (!r_ovalid || o_rsp.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptds_pkg::ST_IDLE:   if (w_acc) n_state = ptds_pkg::ST_UNLINK;
            ptds_pkg::ST_UNLINK: begin
                if (r_mode == ptds_pkg::MODE_DONE && r_run && !r_fail)
                    n_state = ptds_pkg::ST_WALK;
                else
                    n_state = ptds_pkg::ST_OUT;
            end
            ptds_pkg::ST_WALK:   if (w_walk_end) n_state = ptds_pkg::ST_INSERT;
            ptds_pkg::ST_INSERT: n_state = ptds_pkg::ST_OUT;
            ptds_pkg::ST_OUT:    if (w_out_load) n_state = ptds_pkg::ST_IDLE;
            default:             n_state = ptds_pkg::ST_IDLE;
        endcase
    end

    // cell commands
    always_comb begin
        w_cmd = '0;
        w_cmd.key_base   = r_kbase;
        w_cmd.key_period = r_kper;
        w_cmd.ins_pos    = 9'(r_pos);
        case (r_state)
            ptds_pkg::ST_UNLINK: begin
                case (r_mode)
                    ptds_pkg::MODE_ADD: begin
                        // new task is due at once: base = now - period
                        w_cmd.ins        = w_id_ok && !w_is_listed;
                        w_cmd.key_id     = r_tid;
                        w_cmd.key_base   = r_now - r_per;
                        w_cmd.key_period = r_per;
                    end
                    ptds_pkg::MODE_DEL: begin
                        w_cmd.unlink = w_is_listed;
                        w_cmd.key_id = r_tid;
                    end
                    ptds_pkg::MODE_DONE: begin
                        w_cmd.unlink = r_run;
                        w_cmd.key_id = r_run_id;
                    end
                    default: w_cmd.key_id = r_tid;
                endcase
            end
            ptds_pkg::ST_INSERT: begin
                w_cmd.ins    = 1'b1;
                w_cmd.key_id = r_run_id;
            end
            default: w_cmd.key_id = r_tid;
        endcase
        if (r_state == ptds_pkg::ST_UNLINK && r_mode == ptds_pkg::MODE_ADD)
            w_cmd.ins_pos = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ptds_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_listed <= '0;
            r_run    <= 1'b0;
            r_run_id <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_ovalid   <= 1'b1;
                r_o_sv     <= r_sv;
                r_o_sid    <= r_sid;
                r_o_status <= r_status;
                r_o_empty  <= (r_cnt == '0);
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ptds_pkg::ST_IDLE: begin
                    if (w_acc) begin
                        r_mode <= i_req.mode;
                        r_tid  <= i_req.task_id;
                        r_per  <= i_req.task_period;
                        r_now  <= i_req.now_time;
                        r_fail <= i_req.failed;
                    end
                end
                ptds_pkg::ST_UNLINK: begin
                    r_sv     <= 1'b0;
                    r_sid    <= '0;
                    r_status <= 1'b0;
                    r_pos    <= '0;
                    case (r_mode)
                        ptds_pkg::MODE_ADD: begin
                            if (w_id_ok && !w_is_listed) begin
                                r_cnt   <= r_cnt + CW'(1);
                                r_listed[w_tidx] <= 1'b1;
                            end else r_status <= 1'b1;
                        end
                        ptds_pkg::MODE_DEL: begin
                            if (w_is_listed) begin
                                r_cnt <= r_cnt - CW'(1);
                                r_listed[w_tidx] <= 1'b0;
                                if (r_run && r_run_id == r_tid) begin
                                    r_run    <= 1'b0;
                                    r_run_id <= '0;
                                end
                            end else r_status <= 1'b1;
                        end
                        ptds_pkg::MODE_POLL: begin
                            if (!r_run && r_cnt != '0 && w_due) begin
                                r_run      <= 1'b1;
                                r_run_id   <= w_id[0];
                                r_run_base <= w_bs[0];
                                r_run_per  <= w_pr[0];
                                r_sv       <= 1'b1;
                                r_sid      <= w_id[0];
                            end
                        end
                        default: begin
                            if (r_run) begin
                                // running task is always listed; its times
                                // cannot change while it runs
                                r_run <= 1'b0;
                                r_cnt <= r_cnt - CW'(1);
                                r_listed[w_ridx] <= 1'b0;
                                r_kbase <= r_run_base + r_run_per;
                                r_kper  <= r_run_per;
                                if (r_fail) r_run_id <= '0;
                            end else r_status <= 1'b1;
                        end
                    endcase
                end
                ptds_pkg::ST_WALK: begin
                    if (!w_walk_end) r_pos <= r_pos + CW'(1);
                end
                ptds_pkg::ST_INSERT: begin
                    r_cnt <= r_cnt + CW'(1);
                    r_listed[w_ridx] <= 1'b1;
                    r_run_id <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.start_valid = r_o_sv;
    assign o_rsp.start_id    = r_o_sid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.list_empty  = r_o_empty;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TASKS)) else $error("list count overflow");
    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ptds_pkg::ST_IDLE |-> 32'($countones(r_listed)) == 32'(r_cnt))
        else $error("listed bits disagree with count");
    a_run_listed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptds_pkg::ST_IDLE && r_run) |-> r_listed[w_ridx])
        else $error("running task not listed");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !i_req.ready) else $error("accept while busy");
`endif
endmodule

### verif/ptds_sched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptds_sched_checker
// Watches request and result channels, predicts each result word with a
// private copy of the task list, and counts mismatches.
// ----------------------------------------------------------------------------
module ptds_sched_checker #(
    parameter int TASKS = ptds_pkg::TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptds_in_if          req,
    ptds_out_if         rsp,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_starts
);

    typedef struct packed {
        logic       start_valid;
        logic [3:0] start_id;
        logic       list_empty;
        logic       status;
    } t_result;

    logic [3:0]  order_q [TASKS];
    int          listed_n;
    logic        listed_q [TASKS];
    logic [31:0] base_q [TASKS];
    logic [31:0] period_q [TASKS];
    logic        run_flag;
    logic [3:0]  run_id;
    t_result     result_fifo [$];

    assign o_pending = result_fifo.size();

    function automatic void drop_slot(input int id);
        int i;
        int j;
        for (i = 0; i < listed_n; i++) begin
            if (order_q[i] == id) begin
                for (j = i; j + 1 < listed_n; j++) order_q[j] = order_q[j+1];
                listed_n--;
                break;
            end
        end
        listed_q[id] = 1'b0;
    endfunction

    function automatic void place_slot(input int pos, input int id);
        int j;
        if (listed_n >= TASKS || pos > listed_n) return;
        for (j = listed_n; j > pos; j--) order_q[j] = order_q[j-1];
        order_q[pos] = id[3:0];
        listed_n++;
        listed_q[id] = 1'b1;
    endfunction

    function automatic t_result predict_schedule(input ptds_pkg::t_mode mode,
                                                 input int id,
                                                 input logic [31:0] per,
                                                 input logic [31:0] now,
                                                 input logic fail);
        t_result r;
        int h;
        int t;
        int pos;
        logic signed [31:0] mine;
        logic signed [31:0] theirs;
        r = '0;
        case (mode)
            ptds_pkg::MODE_ADD: begin
                if (id >= TASKS || listed_q[id]) r.status = 1'b1;
                else begin
                    period_q[id] = per;
                    base_q[id]   = now - per;
                    place_slot(0, id);
                end
            end
            ptds_pkg::MODE_DEL: begin
                if (id >= TASKS || !listed_q[id]) r.status = 1'b1;
                else begin
                    drop_slot(id);
                    if (run_flag && run_id == id) begin
                        run_flag = 1'b0;
                        run_id   = '0;
                    end
                end
            end
            ptds_pkg::MODE_POLL: begin
                if (!run_flag && listed_n > 0) begin
                    h = order_q[0];
                    if (32'(now - base_q[h]) >= period_q[h]) begin
                        run_flag      = 1'b1;
                        run_id        = h[3:0];
                        r.start_valid = 1'b1;
                        r.start_id    = h[3:0];
                    end
                end
            end
            default: begin
                if (!run_flag) r.status = 1'b1;
                else begin
                    t = run_id;
                    run_flag = 1'b0;
                    run_id   = '0;
                    drop_slot(t);
                    if (!fail) begin
                        base_q[t] = base_q[t] + period_q[t];
                        mine = base_q[t] + period_q[t] - now;
                        for (pos = 0; pos < listed_n; pos++) begin
                            theirs = base_q[order_q[pos]] + period_q[order_q[pos]] - now;
                            if (mine < theirs) break;
                        end
                        place_slot(pos, t);
                    end
                end
            end
        endcase
        r.list_empty = (listed_n == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (!i_rst_n) begin
            listed_n <= 0;
            run_flag <= 1'b0;
            run_id   <= '0;
            for (int k = 0; k < TASKS; k++) listed_q[k] <= 1'b0;
            result_fifo.delete();
            o_errors  <= 0;
            o_results <= 0;
            o_starts  <= 0;
        end else begin
            if (req.valid && req.ready)
                result_fifo.push_back(predict_schedule(ptds_pkg::t_mode'(req.mode),
                    int'(req.task_id), req.task_period, req.now_time, req.failed));
            if (rsp.valid && rsp.ready) begin
                got = {rsp.start_valid, rsp.start_id, rsp.list_empty, rsp.status};
                o_results <= o_results + 1;
                if (got.start_valid) o_starts <= o_starts + 1;
                if (result_fifo.size() == 0) begin
                    $error("result word with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = result_fifo.pop_front();
                    if (exp_r != got) o_errors <= o_errors + 1;
                    if (exp_r.start_valid != got.start_valid)
                        $error("start_valid exp %0d got %0d", exp_r.start_valid,
                               got.start_valid);
                    if (exp_r.start_id != got.start_id)
                        $error("start_id exp %0d got %0d", exp_r.start_id, got.start_id);
                    if (exp_r.list_empty != got.list_empty)
                        $error("list_empty exp %0d got %0d", exp_r.list_empty,
                               got.list_empty);
                    if (exp_r.status != got.status)
                        $error("status exp %0d got %0d", exp_r.status, got.status);
                end
            end
        end
    end

endmodule

### verif/periodic_task_deadline_scheduler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_deadline_scheduler_unit_tb
// Drives add, delete, poll and completion words into the scheduler with
// random gaps and stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module periodic_task_deadline_scheduler_unit_tb;

    localparam int RANDOM_WORDS = 1230;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_cnt = 0;
    int   errors, pending, results, starts;
    int   words_sent = 0;
    int   hold_reqs = 0;       // long receiver stalls asked for
    int   holds_done = 0;      // long receiver stalls finished
    logic quiet = 1'b0;        // last stretch: no idling on either side
    logic [31:0] clock_us = 32'h0;

    ptds_in_if  req_ch ();
    ptds_out_if rsp_ch ();

    periodic_task_deadline_scheduler_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    ptds_sched_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_results (results),
        .o_starts  (starts)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("periodic_task_deadline_scheduler_unit_tb: errors");
            $finish;
        end
    end

    // Receiver: bursts of ready low, a long hold when asked, none at the end.
    initial begin
        int n;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done < hold_reqs) begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                holds_done <= holds_done + 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n - 1) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Hands one word to the block and waits for the accept.
    task automatic send_word(input ptds_pkg::t_mode m, input logic [3:0] id,
                             input logic [31:0] per, input logic [31:0] now,
                             input logic fail);
        int n;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 10);
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= m;
        req_ch.task_id     <= id;
        req_ch.task_period <= per;
        req_ch.now_time    <= now;
        req_ch.failed      <= fail;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int r;
        logic [31:0] per;
        req_ch.valid = 1'b0;
        req_ch.mode = ptds_pkg::MODE_POLL;
        req_ch.task_id = '0;
        req_ch.task_period = '0;
        req_ch.now_time = '0;
        req_ch.failed = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list cases, extremes, rejections.
        send_word(ptds_pkg::MODE_POLL, 4'd0, 32'h0, 32'h0, 1'b0);
        send_word(ptds_pkg::MODE_DONE, 4'd0, 32'h0, 32'h0, 1'b1);
        send_word(ptds_pkg::MODE_DEL, 4'd15, 32'h0, 32'h0, 1'b0);
        send_word(ptds_pkg::MODE_ADD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(ptds_pkg::MODE_ADD, 4'd15, 32'h5, 32'h0, 1'b0);
        send_word(ptds_pkg::MODE_ADD, 4'd0, 32'h0, 32'h0, 1'b0);
        send_word(ptds_pkg::MODE_ADD, 4'd7, 32'h10, 32'h8000_0000, 1'b0);
        send_word(ptds_pkg::MODE_POLL, 4'd0, 32'h0, 32'h8000_0000, 1'b0);
        send_word(ptds_pkg::MODE_POLL, 4'd0, 32'h0, 32'h8000_0001, 1'b0);
        send_word(ptds_pkg::MODE_DONE, 4'd0, 32'h0, 32'h8000_0004, 1'b0);
        send_word(ptds_pkg::MODE_POLL, 4'd0, 32'h0, 32'h8000_0005, 1'b0);
        send_word(ptds_pkg::MODE_DEL, 4'd0, 32'h0, 32'h8000_0006, 1'b0);
        send_word(ptds_pkg::MODE_DONE, 4'd0, 32'h0, 32'h8000_0007, 1'b0);
        send_word(ptds_pkg::MODE_POLL, 4'd0, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_word(ptds_pkg::MODE_DONE, 4'd0, 32'h0, 32'hFFFF_FFFF, 1'b1);
        send_word(ptds_pkg::MODE_POLL, 4'd0, 32'h0, 32'h0000_0003, 1'b0);
        send_word(ptds_pkg::MODE_DONE, 4'd0, 32'h0, 32'h0000_0004, 1'b0);
        send_word(ptds_pkg::MODE_DEL, 4'd7, 32'h0, 32'h0, 1'b0);
        send_word(ptds_pkg::MODE_DEL, 4'd15, 32'h0, 32'h0, 1'b0);
        drain_results();
        clock_us = $urandom;

        // Long receiver hold while words keep coming, so the block backs up.
        hold_reqs <= hold_reqs + 1;
        for (int k = 0; k < 16; k++)
            send_word(ptds_pkg::MODE_ADD, k[3:0], $urandom_range(1, 200), clock_us,
                      1'b0);

        // Random: mostly poll/complete cycles on a moving clock.
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k == RANDOM_WORDS - 200) quiet <= 1'b1;
            if (k == RANDOM_WORDS / 2) drain_results();
            clock_us = clock_us + $urandom_range(0, 60);
            r = $urandom_range(0, 99);
            per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
            if (r < 12)
                send_word(ptds_pkg::MODE_ADD, 4'($urandom), per, clock_us, 1'b0);
            else if (r < 20)
                send_word(ptds_pkg::MODE_DEL, 4'($urandom), per, clock_us,
                          1'($urandom));
            else if (r < 58)
                send_word(ptds_pkg::MODE_POLL, 4'($urandom), $urandom, clock_us,
                          1'($urandom));
            else if (r < 97)
                send_word(ptds_pkg::MODE_DONE, 4'($urandom), $urandom, clock_us,
                          $urandom_range(0, 7) == 0);
            else
                send_word(ptds_pkg::t_mode'($urandom_range(0, 3)), 4'($urandom),
                          $urandom, $urandom, 1'($urandom));
        end
        drain_results();
        repeat (40) @(posedge i_clk);

        $display("covered %0d request words, %0d result words, %0d task starts",
                 words_sent, results, starts);
        if (errors == 0 && pending == 0)
            $display("periodic_task_deadline_scheduler_unit_tb: clean");
        else
            $display("periodic_task_deadline_scheduler_unit_tb: errors");
        $finish;
    end

endmodule
